// ===== src/pve_pkg.sv =====
// ----------------------------------------------------------------------------
// pve_pkg
// Shared types and constants for the pointer velocity estimator.
// ----------------------------------------------------------------------------
`default_nettype none
package pve_pkg;
	localparam int MAX_ENTRIES_DEF = 128;
	localparam logic [7:0] WIN_RESET = 8'd100;
	localparam int VEL_W = 34;

	localparam logic [1:0] ST_VALID = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_ZERO_DT = 2'd2;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [31:0] t;
		logic start;
	} sample_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic [1:0] status;
	} result_t;
endpackage
`default_nettype wire

// ===== src/pve_queue.sv =====
// ----------------------------------------------------------------------------
// pve_queue
// Two-entry queue between the sample front end and the estimator engine.
// ----------------------------------------------------------------------------
`default_nettype none
module pve_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire pve_pkg::sample_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output pve_pkg::sample_t out_data
);
	import pve_pkg::*;

	sample_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== src/pve_divider.sv =====
// ----------------------------------------------------------------------------
// pve_divider
// Radix-2 restoring divider for unsigned magnitudes, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pve_divider #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [NW-1:0] num,
	input wire logic [DW-1:0] den,
	output logic busy,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] q_q;
	logic [DW:0] r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0] trial;
	logic [DW+1:0] diff;

	assign busy = (cnt_q != '0);
	assign quo = q_q;
	assign trial = {r_q[DW-1:0], q_q[NW-1]};
	assign diff = {1'b0, trial} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy) begin
			if (!diff[DW+1]) begin
				r_q <= diff[DW:0];
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/pve_engine.sv =====
// ----------------------------------------------------------------------------
// pve_engine
// History ring and estimator sequencer: stores one sample, walks the pairs,
// divides each slope serially and averages them.
// ----------------------------------------------------------------------------
`default_nettype none
module pve_engine #(
	parameter int MAX_ENTRIES = pve_pkg::MAX_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire pve_pkg::sample_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output pve_pkg::result_t out_data
);
	import pve_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int SW = CW + 34;
	localparam int NW = SW;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_PREV = 11'b00000000010,
		S_STORE = 11'b00000000100,
		S_RD2 = 11'b00000001000,
		S_RD1 = 11'b00000010000,
		S_WAIT1 = 11'b00000100000,
		S_DIVX = 11'b00001000000,
		S_DIVY = 11'b00010000000,
		S_MEANX = 11'b00100000000,
		S_MEANY = 11'b01000000000,
		S_OUT = 11'b10000000000
	} state_t;

	state_t st_q;
	logic signed [15:0] xm [MAX_ENTRIES];
	logic signed [15:0] ym [MAX_ENTRIES];
	logic [31:0] tm [MAX_ENTRIES];
	logic signed [15:0] rx_q, ry_q;
	logic [31:0] rt_q;
	logic [AW-1:0] raddr;

	logic [CW-1:0] size_q, fill_q, pairs_q, step_q, i_q;
	logic [AW-1:0] wslot_q, i2_q;
	logic [7:0] win_q;
	sample_t smp_q;
	logic signed [15:0] x2_q, y2_q;
	logic [31:0] t2_q, dt_q;
	logic signed [16:0] dx_q, dy_q;
	logic signed [SW-1:0] sx_q, sy_q;
	result_t res_q;
	logic outv_q;

	logic div_start, div_busy;
	logic [NW-1:0] div_num, div_quo;
	logic [31:0] div_den;

	pve_divider #(.NW(NW), .DW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .quo(div_quo)
	);

	function automatic logic [AW-1:0] wrap_sub(logic [AW-1:0] a, logic [CW-1:0] b,
			logic [CW-1:0] sz);
		logic [CW:0] s;
		s = {1'b0, CW'(a)} + {1'b0, sz} - {1'b0, b};
		if (s >= {1'b0, sz}) s = s - {1'b0, sz};
		return s[AW-1:0];
	endfunction

	logic [CW-1:0] wsize;
	always_comb begin
		if (win_q == 8'd0) wsize = CW'(1);
		else if ({24'd0, win_q} > MAX_ENTRIES) wsize = CW'(MAX_ENTRIES);
		else wsize = CW'(win_q);
	end

	logic [AW-1:0] wslot_eff, prev_a;
	logic [CW-1:0] fill_eff;
	always_comb begin
		wslot_eff = (smp_q.start || CW'(wslot_q) >= size_q) ? '0 : wslot_q;
		fill_eff = smp_q.start ? '0 : ((fill_q > size_q) ? size_q : fill_q);
		prev_a = wrap_sub(wslot_eff, CW'(1), size_q);
	end

	logic hit;
	assign hit = (fill_eff != '0) && (rt_q == smp_q.t);

	always_comb begin
		unique case (st_q)
			S_IDLE, S_PREV: raddr = prev_a;
			S_RD2: raddr = i2_q;
			default: raddr = wrap_sub(i2_q, step_q, size_q);
		endcase
	end

	always_ff @(posedge clk) begin
		rx_q <= xm[raddr];
		ry_q <= ym[raddr];
		rt_q <= tm[raddr];
		if (st_q == S_STORE) begin
			if (hit) begin
				xm[prev_a] <= smp_q.x;
				ym[prev_a] <= smp_q.y;
			end else begin
				xm[wslot_eff] <= smp_q.x;
				ym[wslot_eff] <= smp_q.y;
				tm[wslot_eff] <= smp_q.t;
			end
		end
	end

	logic [CW-1:0] fill_new;
	logic [AW-1:0] wslot_new;
	always_comb begin
		fill_new = (hit || fill_eff >= size_q) ? fill_eff : fill_eff + 1'b1;
		if (hit) wslot_new = wslot_eff;
		else if (CW'(wslot_eff) + 1'b1 >= size_q) wslot_new = '0;
		else wslot_new = wslot_eff + 1'b1;
	end

	logic [16:0] dmag;
	logic signed [16:0] dcur;
	logic [SW-1:0] smag;
	logic signed [SW-1:0] scur;
	always_comb begin
		dcur = (st_q == S_DIVX) ? dx_q : dy_q;
		dmag = dcur[16] ? 17'(-dcur) : dcur;
		scur = (st_q == S_MEANX) ? sx_q : sy_q;
		smag = scur[SW-1] ? SW'(-scur) : scur;
	end

	logic phase_q;
	always_comb begin
		div_start = 1'b0;
		div_num = '0;
		div_den = dt_q;
		if ((st_q == S_DIVX || st_q == S_DIVY) && !phase_q) begin
			div_start = 1'b1;
			div_num = NW'({dmag, 16'd0});
		end else if ((st_q == S_MEANX || st_q == S_MEANY) && !phase_q) begin
			div_start = 1'b1;
			div_num = smag;
			div_den = 32'(pairs_q);
		end
	end

	logic signed [SW-1:0] qsig;
	always_comb begin
		qsig = SW'(div_quo);
		if (st_q == S_DIVX || st_q == S_DIVY) begin
			if (dcur[16]) qsig = -qsig;
		end else if (scur[SW-1]) begin
			qsig = -qsig;
		end
	end

	assign in_ready = (st_q == S_IDLE) && !outv_q;
	assign out_valid = outv_q;
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			win_q <= WIN_RESET;
			fill_q <= '0;
			wslot_q <= '0;
			outv_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (outv_q && out_ready) outv_q <= 1'b0;
			if (cfg_we) begin
				win_q <= cfg_data;
				fill_q <= '0;
				wslot_q <= '0;
			end
			unique case (st_q)
				S_IDLE: if (in_valid && in_ready) st_q <= S_PREV;
				S_PREV: st_q <= S_STORE;
				S_STORE: begin
					fill_q <= fill_new;
					wslot_q <= wslot_new;
					if (fill_new <= CW'(1)) begin
						res_q <= '{vx: '0, vy: '0, status: ST_FEW};
						st_q <= S_OUT;
					end else begin
						st_q <= S_RD2;
					end
				end
				S_RD2: st_q <= S_RD1;
				S_RD1: st_q <= S_WAIT1;
				S_WAIT1: begin
					dt_q <= t2_q - rt_q;
					dx_q <= 17'(x2_q) - 17'(rx_q);
					dy_q <= 17'(y2_q) - 17'(ry_q);
					if (t2_q == rt_q) begin
						res_q <= '{vx: '0, vy: '0, status: ST_ZERO_DT};
						st_q <= S_OUT;
					end else begin
						st_q <= S_DIVX;
					end
				end
				S_DIVX, S_DIVY, S_MEANX, S_MEANY: begin
					if (!phase_q) phase_q <= 1'b1;
					else if (!div_busy) begin
						phase_q <= 1'b0;
						unique case (st_q)
							S_DIVX: st_q <= S_DIVY;
							S_DIVY: begin
								if (i_q + 1'b1 >= pairs_q) st_q <= S_MEANX;
								else st_q <= S_RD2;
							end
							S_MEANX: begin
								res_q.vx <= VEL_W'(qsig);
								st_q <= S_MEANY;
							end
							default: begin
								res_q.vy <= VEL_W'(qsig);
								res_q.status <= ST_VALID;
								st_q <= S_OUT;
							end
						endcase
					end
				end
				S_OUT: begin
					outv_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid && in_ready) begin
			smp_q <= in_data;
			size_q <= wsize;
		end
		if (st_q == S_STORE) begin
			step_q <= fill_new >> 1;
			pairs_q <= (fill_new >> 1) + CW'(fill_new[0]);
			i_q <= '0;
			i2_q <= wrap_sub(wslot_new, CW'(1), size_q);
			sx_q <= '0;
			sy_q <= '0;
		end
		if (st_q == S_RD1) begin
			x2_q <= rx_q;
			y2_q <= ry_q;
			t2_q <= rt_q;
		end
		if ((st_q == S_DIVX || st_q == S_DIVY) && phase_q && !div_busy) begin
			if (st_q == S_DIVX) begin
				sx_q <= sx_q + qsig;
			end else begin
				sy_q <= sy_q + qsig;
				i_q <= i_q + 1'b1;
				i2_q <= wrap_sub(i2_q, CW'(1), size_q);
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/pointer_velocity_estimator.sv =====
// ----------------------------------------------------------------------------
// pointer_velocity_estimator
// Pointer sample history and signed Q18.16 velocity estimate.
// ----------------------------------------------------------------------------
// One result beat per sample beat. P being the number of averaged pairs
// (up to 64), a full estimate divides 2*P slopes and two means: every
// slope and both means run through one serial divider at one bit a cycle.
// A two-beat queue sits ahead of the engine; results wait in an output
// register. Writing window_entries clears the history.
`default_nettype none
module pointer_velocity_estimator #(
	parameter int MAX_ENTRIES = pve_pkg::MAX_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [7:0] cfg_data,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// [15:0] sample_x, [31:16] sample_y, [63:32] sample_time
	input wire logic [63:0] s_axis_tdata,
	// [0] gesture_start
	input wire logic s_axis_tuser,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// [33:0] vel_x, [67:34] vel_y
	output logic [71:0] m_axis_tdata,
	// [1:0] status
	output logic [1:0] m_axis_tuser
);
	import pve_pkg::*;

	sample_t in_s, q_s;
	result_t res;
	logic q_valid, q_ready;

	assign cfg_ready = 1'b1;
	assign in_s = '{x: s_axis_tdata[15:0], y: s_axis_tdata[31:16],
		t: s_axis_tdata[63:32], start: s_axis_tuser};

	pve_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(in_s), .out_valid(q_valid), .out_ready(q_ready), .out_data(q_s)
	);

	pve_engine #(.MAX_ENTRIES(MAX_ENTRIES)) u_engine (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_valid), .cfg_data(cfg_data),
		.in_valid(q_valid), .in_ready(q_ready), .in_data(q_s),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
	);

	assign m_axis_tdata = {4'd0, res.vy, res.vx};
	assign m_axis_tuser = res.status;
endmodule
`default_nettype wire
